### rtl/hart_slot_allocator_assert.svh
// ----------------------------------------------------------------------------
// hart slot allocator assertion macros
// concurrent checks on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef HART_SLOT_ALLOCATOR_ASSERT_SVH
`define HART_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define HSA_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hart slot allocator check failed");

// next-cycle implication
`define HSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hart slot allocator check failed");

`endif

### rtl/hsa_pkg.sv
// ----------------------------------------------------------------------------
// hsa_pkg
// widths, status codes and transaction types of the hart slot allocator
// ----------------------------------------------------------------------------
package hsa_pkg;

   localparam int NUM_SLOTS = 64;
   localparam int SLOT_W    = 6;
   localparam int CNT_W     = 7;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_REFUSED     = 2'd1;
   localparam logic [1:0] STATUS_BAD_RELEASE = 2'd2;

   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [CNT_W-1:0]  count;
      logic [SLOT_W-1:0] slot_id;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              granted_valid;
      logic [SLOT_W-1:0] granted_slot;
      logic              last;
   } rsp_type;

endpackage

### rtl/hart_slot_allocator.sv
// ----------------------------------------------------------------------------
// hart_slot_allocator
// first-fit allocator of hardware thread slots over an in-use bitmap
// ----------------------------------------------------------------------------
// A release, a refused request and a zero-count request each give one result,
// strobed on rsp_valid in the cycle after acceptance; busy stays low for them.
// A request that passes the count check runs a single slot scanner twice: a
// count pass over the L usable slots (L = min(slot_count, NUM_SLOTS)), then
// the grant pass, which visits one slot per cycle up to the last granted
// one, one granted slot per result. A request holds busy through both
// passes. Results come out on a strobe that cannot be stalled; each is valid
// for one cycle only. The configuration port is always ready and is to be
// written by the user only while busy is low; the block does not enforce it.
`include "hart_slot_allocator_assert.svh"

module hart_slot_allocator (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  hsa_pkg::req_type        req_item,
   output logic                    rsp_valid,
   output hsa_pkg::rsp_type        rsp_item,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [hsa_pkg::CNT_W-1:0] csr_data
);
   import hsa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_COUNT = 3'b010,
      ST_ALLOC = 3'b100
   } state_type;

   state_type            state_ff,      state_in;
   logic [NUM_SLOTS-1:0] slot_busy_ff,  slot_busy_in;
   logic [CNT_W-1:0]     busy_count_ff, busy_count_in;
   logic [CNT_W-1:0]     slot_count_ff;
   logic [CNT_W-1:0]     scan_ff,       scan_in;
   logic [CNT_W-1:0]     free_ff,       free_in;
   logic [CNT_W-1:0]     grant_n_ff,    grant_n_in;
   logic [CNT_W-1:0]     req_count_ff,  req_count_in;
   logic                 rsp_valid_ff,  rsp_valid_in;
   rsp_type              rsp_ff,        rsp_in;

   logic [CNT_W-1:0] limit;
   logic [CNT_W:0]   demand;
   logic             accept;
   logic             scan_bit;
   logic             release_ok;
   logic             grant_last;

   assign accept    = start && !busy;
   assign limit     = (slot_count_ff > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : slot_count_ff;
   assign demand    = {1'b0, busy_count_ff} + {1'b0, req_item.count};
   assign scan_bit  = slot_busy_ff[scan_ff[IDX_W-1:0]];
   assign release_ok = ({1'b0, req_item.slot_id} < CNT_W'(NUM_SLOTS))
                       && slot_busy_ff[req_item.slot_id[IDX_W-1:0]];
   assign grant_last = (grant_n_ff + CNT_W'(1)) == req_count_ff;

   always_comb begin
      state_in      = state_ff;
      slot_busy_in  = slot_busy_ff;
      busy_count_in = busy_count_ff;
      scan_in       = scan_ff;
      free_in       = free_ff;
      grant_n_in    = grant_n_ff;
      req_count_in  = req_count_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.granted_valid = 1'b0;
               rsp_in.granted_slot  = '0;
               rsp_in.last          = 1'b1;
               if (req_item.kind == KIND_RELEASE) begin
                  rsp_valid_in = 1'b1;
                  if (release_ok) begin
                     slot_busy_in[req_item.slot_id[IDX_W-1:0]] = 1'b0;
                     if (busy_count_ff != '0) begin
                        busy_count_in = busy_count_ff - CNT_W'(1);
                     end
                     rsp_in.status = STATUS_OK;
                  end else begin
                     rsp_in.status = STATUS_BAD_RELEASE;
                  end
               end else if (demand > {1'b0, limit}) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_REFUSED;
               end else if (req_item.count == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_OK;
               end else begin
                  req_count_in = req_item.count;
                  scan_in      = '0;
                  free_in      = '0;
                  state_in     = ST_COUNT;
               end
            end
         end
         ST_COUNT: begin
            if (scan_ff == limit) begin
               if (free_ff < req_count_ff) begin
                  // fewer free slots below the limit than requested
                  rsp_valid_in         = 1'b1;
                  rsp_in.status        = STATUS_REFUSED;
                  rsp_in.granted_valid = 1'b0;
                  rsp_in.granted_slot  = '0;
                  rsp_in.last          = 1'b1;
                  state_in             = ST_IDLE;
               end else begin
                  scan_in    = '0;
                  grant_n_in = '0;
                  state_in   = ST_ALLOC;
               end
            end else begin
               if (!scan_bit) begin
                  free_in = free_ff + CNT_W'(1);
               end
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         ST_ALLOC: begin
            if (!scan_bit) begin
               slot_busy_in[scan_ff[IDX_W-1:0]] = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.status        = STATUS_OK;
               rsp_in.granted_valid = 1'b1;
               rsp_in.granted_slot  = SLOT_W'(scan_ff);
               rsp_in.last          = grant_last;
               grant_n_in           = grant_n_ff + CNT_W'(1);
               if (grant_last) begin
                  busy_count_in = busy_count_ff + req_count_ff;
                  state_in      = ST_IDLE;
               end
            end
            scan_in = scan_ff + CNT_W'(1);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_busy_ff  <= NUM_SLOTS'(1);
         busy_count_ff <= CNT_W'(1);
         slot_count_ff <= CNT_W'(64);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_busy_ff  <= slot_busy_in;
         busy_count_ff <= busy_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            slot_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      free_ff      <= free_in;
      grant_n_ff   <= grant_n_in;
      req_count_ff <= req_count_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign csr_ready = 1'b1;

   `HSA_ASSERT_IMPLY(a_count_bounded, 1'b1, busy_count_ff <= CNT_W'(NUM_SLOTS))
   `HSA_ASSERT_IMPLY(a_count_matches_map, state_ff == ST_IDLE,
                     busy_count_ff == CNT_W'($countones(slot_busy_ff)))
   `HSA_ASSERT_IMPLY(a_grant_marked, rsp_valid_ff && rsp_ff.granted_valid,
                     slot_busy_ff[rsp_ff.granted_slot[IDX_W-1:0]])
   `HSA_ASSERT_IMPLY(a_more_grants_pending, rsp_valid_ff && !rsp_ff.last,
                     state_ff == ST_ALLOC)
   `HSA_ASSERT_NEXT(a_release_answered, accept && req_item.kind == KIND_RELEASE,
                    rsp_valid_ff && rsp_ff.last && !busy)

endmodule
